// File: hw/rtl/clp_pkg.sv
// Shared types and constants of the Cauchy likelihood product block.
package clp_pkg;

    localparam logic [63:0] ONE_BITS     = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] PI_BITS      = 64'h4009_21FB_5444_2D18;
    localparam logic [63:0] QNAN_DEFAULT = 64'hFFF8_0000_0000_0000;

    // Configuration register indexes
    localparam logic CFG_ALPHA = 1'b0;
    localparam logic CFG_BETA  = 1'b1;

    typedef enum logic [1:0] {
        FOP_ADD = 2'd0,
        FOP_SUB = 2'd1,
        FOP_MUL = 2'd2,
        FOP_DIV = 2'd3
    } t_fop;

    typedef struct packed {
        logic        start;
        t_fop        op;
        logic [63:0] a;
        logic [63:0] b;
    } t_fpu_req;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } t_fpu_rsp;

endpackage

// File: hw/rtl/clp_fpu.sv
// Iterative binary64 add, subtract, multiply and divide unit, round to nearest even.
module clp_fpu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  clp_pkg::t_fpu_req  i_req,
    output clp_pkg::t_fpu_rsp  o_rsp
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_ALIGN   = 9'b000000010,
        S_PRENORM = 9'b000000100,
        S_MULT    = 9'b000001000,
        S_DIVIDE  = 9'b000010000,
        S_NORM    = 9'b000100000,
        S_DENORM  = 9'b001000000,
        S_ROUND   = 9'b010000000,
        S_DONE    = 9'b100000000
    } t_fstate;

    t_fstate             r_state, n_state;
    clp_pkg::t_fop       r_op, n_op;
    logic                r_sa, n_sa, r_sb, n_sb, r_sign, n_sign, r_sticky, n_sticky;
    logic signed [13:0]  r_ea, n_ea, r_eb, n_eb, r_e, n_e;
    logic [52:0]         r_ma, n_ma, r_mb, n_mb;
    logic [63:0]         r_sig, n_sig, r_res, n_res;
    logic [105:0]        r_acc, n_acc;
    logic [53:0]         r_pp, n_pp;
    logic [1:0]          r_ppk, n_ppk;
    logic [6:0]          r_cnt, n_cnt;
    logic [54:0]         r_rem, n_rem;

    // operand classification
    logic        a_nan, a_inf, a_zero, b_nan, b_inf, b_zero, sx, sbe;
    logic        special;
    logic [63:0] spec_res;

    // per-state temporaries
    logic               a_big, sl, ss;
    logic signed [13:0] el, es, amt, e_fin;
    logic [13:0]        dsh;
    logic [52:0]        ml, ms, mant;
    logic [63:0]        aw, bw, bsh, sum;
    logic [26:0]        pa, pb;
    logic [105:0]       addend;
    logic               ge, up, gbit, stk;
    logic [54:0]        rem2;
    logic [53:0]        m54;

    always_comb begin
        a_nan  = (&i_req.a[62:52]) && (|i_req.a[51:0]);
        a_inf  = (&i_req.a[62:52]) && !(|i_req.a[51:0]);
        a_zero = !(|i_req.a[62:0]);
        b_nan  = (&i_req.b[62:52]) && (|i_req.b[51:0]);
        b_inf  = (&i_req.b[62:52]) && !(|i_req.b[51:0]);
        b_zero = !(|i_req.b[62:0]);
        sx     = i_req.a[63] ^ i_req.b[63];
        sbe    = (i_req.op == clp_pkg::FOP_SUB) ? ~i_req.b[63] : i_req.b[63];
        special  = 1'b1;
        spec_res = clp_pkg::QNAN_DEFAULT;
        if (a_nan) begin
            spec_res = i_req.a | 64'h0008_0000_0000_0000;
        end else if (b_nan) begin
            spec_res = i_req.b | 64'h0008_0000_0000_0000;
        end else begin
            case (i_req.op) inside
                clp_pkg::FOP_ADD, clp_pkg::FOP_SUB: begin
                    if (a_inf && b_inf && (i_req.a[63] != sbe)) spec_res = clp_pkg::QNAN_DEFAULT;
                    else if (a_inf) spec_res = i_req.a;
                    else if (b_inf) spec_res = {sbe, 11'h7FF, 52'd0};
                    else special = 1'b0;
                end
                clp_pkg::FOP_MUL: begin
                    if ((a_inf && b_zero) || (b_inf && a_zero)) spec_res = clp_pkg::QNAN_DEFAULT;
                    else if (a_inf || b_inf) spec_res = {sx, 11'h7FF, 52'd0};
                    else if (a_zero || b_zero) spec_res = {sx, 63'd0};
                    else special = 1'b0;
                end
                default: begin
                    if ((a_inf && b_inf) || (a_zero && b_zero)) spec_res = clp_pkg::QNAN_DEFAULT;
                    else if (a_inf) spec_res = {sx, 11'h7FF, 52'd0};
                    else if (b_inf) spec_res = {sx, 63'd0};
                    else if (b_zero) spec_res = {sx, 11'h7FF, 52'd0};
                    else if (a_zero) spec_res = {sx, 63'd0};
                    else special = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;  n_op = r_op;  n_sa = r_sa;  n_sb = r_sb;
        n_sign = r_sign;    n_sticky = r_sticky;
        n_ea = r_ea;  n_eb = r_eb;  n_e = r_e;  n_ma = r_ma;  n_mb = r_mb;
        n_sig = r_sig;  n_res = r_res;  n_acc = r_acc;  n_pp = r_pp;  n_ppk = r_ppk;
        n_cnt = r_cnt;  n_rem = r_rem;
        a_big = 1'b0;  sl = 1'b0;  ss = 1'b0;  el = '0;  es = '0;  amt = '0;  e_fin = '0;
        dsh = '0;  ml = '0;  ms = '0;  mant = '0;  aw = '0;  bw = '0;  bsh = '0;  sum = '0;
        pa = '0;  pb = '0;  addend = '0;  ge = 1'b0;  up = 1'b0;  gbit = 1'b0;  stk = 1'b0;
        rem2 = '0;  m54 = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_op   = i_req.op;
                    n_sa   = i_req.a[63];
                    n_sb   = sbe;
                    n_sign = sx;
                    n_ea   = (|i_req.a[62:52]) ? $signed({3'b000, i_req.a[62:52]}) : 14'sd1;
                    n_eb   = (|i_req.b[62:52]) ? $signed({3'b000, i_req.b[62:52]}) : 14'sd1;
                    n_ma   = {|i_req.a[62:52], i_req.a[51:0]};
                    n_mb   = {|i_req.b[62:52], i_req.b[51:0]};
                    if (special) begin
                        n_res   = spec_res;
                        n_state = S_DONE;
                    end else if (i_req.op == clp_pkg::FOP_ADD || i_req.op == clp_pkg::FOP_SUB) begin
                        n_state = S_ALIGN;
                    end else begin
                        n_state = S_PRENORM;
                    end
                end
            end
            S_ALIGN: begin
                a_big = (r_ea > r_eb) || ((r_ea == r_eb) && (r_ma >= r_mb));
                el = a_big ? r_ea : r_eb;   es = a_big ? r_eb : r_ea;
                ml = a_big ? r_ma : r_mb;   ms = a_big ? r_mb : r_ma;
                sl = a_big ? r_sa : r_sb;   ss = a_big ? r_sb : r_sa;
                dsh = el - es;
                aw  = {1'b0, ml, 10'd0};
                bw  = {1'b0, ms, 10'd0};
                // fold shifted-out bits into a sticky lsb
                if (dsh >= 14'd64) begin
                    bsh = {63'd0, |bw};
                end else begin
                    bsh = (bw >> dsh[5:0])
                        | {63'd0, |(bw & ((64'd1 << dsh[5:0]) - 64'd1))};
                end
                sum      = (sl == ss) ? aw + bsh : aw - bsh;
                n_sig    = sum;
                n_sticky = 1'b0;
                n_e      = el + 14'sd1;
                n_sign   = (sum == 64'd0) ? (r_sa & r_sb) : sl;
                n_state  = S_NORM;
            end
            S_PRENORM: begin
                if (!r_ma[52]) begin
                    n_ma = {r_ma[51:0], 1'b0};
                    n_ea = r_ea - 14'sd1;
                end
                if (!r_mb[52]) begin
                    n_mb = {r_mb[51:0], 1'b0};
                    n_eb = r_eb - 14'sd1;
                end
                if (r_ma[52] && r_mb[52]) begin
                    n_cnt = '0;
                    n_acc = '0;
                    n_rem = {2'b00, r_ma};
                    n_state = (r_op == clp_pkg::FOP_MUL) ? S_MULT : S_DIVIDE;
                end
            end
            S_MULT: begin
                // four 27x27 partial products, each registered before accumulation
                case (r_cnt[1:0])
                    2'd0:    begin pa = {1'b0, r_ma[25:0]}; pb = {1'b0, r_mb[25:0]}; end
                    2'd1:    begin pa = {1'b0, r_ma[25:0]}; pb = r_mb[52:26]; end
                    2'd2:    begin pa = r_ma[52:26]; pb = {1'b0, r_mb[25:0]}; end
                    default: begin pa = r_ma[52:26]; pb = r_mb[52:26]; end
                endcase
                n_pp  = pa * pb;
                n_ppk = r_cnt[1:0];
                case (r_ppk) inside
                    2'd0:       addend = {52'd0, r_pp};
                    2'd1, 2'd2: addend = {26'd0, r_pp, 26'd0};
                    default:    addend = {r_pp, 52'd0};
                endcase
                if (r_cnt != 7'd0) n_acc = r_acc + addend;
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd4) begin
                    n_sig    = n_acc[105:42];
                    n_sticky = |n_acc[41:0];
                    n_e      = r_ea + r_eb - 14'sd1022;
                    n_state  = S_NORM;
                end
            end
            S_DIVIDE: begin
                ge    = r_rem >= {2'b00, r_mb};
                rem2  = ge ? r_rem - {2'b00, r_mb} : r_rem;
                n_rem = {rem2[53:0], 1'b0};
                n_sig = {r_sig[62:0], ge};
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    n_sticky = |rem2;
                    n_e      = r_ea - r_eb + 14'sd1023;
                    n_state  = S_NORM;
                end
            end
            S_NORM: begin
                if (r_sig == 64'd0 && !r_sticky) begin
                    n_res   = {r_sign, 63'd0};
                    n_state = S_DONE;
                end else if (!r_sig[63] && (r_e > 14'sd1)) begin
                    n_sig = {r_sig[62:0], 1'b0};
                    n_e   = r_e - 14'sd1;
                end else begin
                    n_state = S_DENORM;
                end
            end
            S_DENORM: begin
                if (r_e < 14'sd1) begin
                    amt = 14'sd1 - r_e;
                    if (amt >= 14'sd64) begin
                        n_sig    = '0;
                        n_sticky = r_sticky | (|r_sig);
                    end else begin
                        n_sig    = r_sig >> amt[5:0];
                        n_sticky = r_sticky | (|(r_sig & ((64'd1 << amt[5:0]) - 64'd1)));
                    end
                    n_e = 14'sd1;
                end
                n_state = S_ROUND;
            end
            S_ROUND: begin
                gbit = r_sig[10];
                stk  = (|r_sig[9:0]) | r_sticky;
                up   = gbit & (stk | r_sig[11]);
                m54  = {1'b0, r_sig[63:11]} + {53'd0, up};
                if (m54[53]) begin
                    mant  = m54[53:1];
                    e_fin = r_e + 14'sd1;
                end else begin
                    mant  = m54[52:0];
                    e_fin = r_e;
                end
                if (e_fin > 14'sd2046) begin
                    n_res = {r_sign, 11'h7FF, 52'd0};
                end else begin
                    n_res = {r_sign, (mant[52] ? e_fin[10:0] : 11'd0), mant[51:0]};
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;  r_sa <= n_sa;  r_sb <= n_sb;  r_sign <= n_sign;  r_sticky <= n_sticky;
        r_ea <= n_ea;  r_eb <= n_eb;  r_e <= n_e;  r_ma <= n_ma;  r_mb <= n_mb;
        r_sig <= n_sig;  r_res <= n_res;  r_acc <= n_acc;  r_pp <= n_pp;  r_ppk <= n_ppk;
        r_cnt <= n_cnt;  r_rem <= n_rem;
    end

    assign o_rsp.done = (r_state == S_DONE);
    assign o_rsp.res  = r_res;

endmodule

// File: hw/rtl/cauchy_likelihood_product_core.sv
// Each item runs seven binary64 operations in series on one shared unit, among them a
// 64-step restoring divide; the normalize loop shifts the significand one bit per cycle.
// The core takes no new sample until the current one is through; a finished product may
// wait in the output register, and the next last sample's product waits until it is free.
// Reset (synchronous, active low): alpha 0.0, beta 1.0, running product 1.0, no result.
module cauchy_likelihood_product_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [63:0] sample_bits
    input  logic        i_s_axis_tlast,   // last_point
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [63:0] product_bits
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    typedef enum logic [8:0] {
        C_IDLE = 9'b000000001,
        C_DIFF = 9'b000000010,
        C_DSQ  = 9'b000000100,
        C_BSQ  = 9'b000001000,
        C_SUM  = 9'b000010000,
        C_DEN  = 9'b000100000,
        C_DIV  = 9'b001000000,
        C_PROD = 9'b010000000,
        C_EMIT = 9'b100000000
    } t_cstate;

    t_cstate           r_state;
    logic              r_start, r_last, r_ovalid;
    logic [63:0]       r_alpha, r_beta, r_x, r_t1, r_t2, r_run, r_odata;
    clp_pkg::t_fpu_req fpu_req;
    clp_pkg::t_fpu_rsp fpu_rsp;
    logic              accept;

    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == C_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    always_comb begin
        fpu_req.start = r_start;
        fpu_req.op    = clp_pkg::FOP_MUL;
        fpu_req.a     = r_t1;
        fpu_req.b     = r_t1;
        unique case (r_state)
            C_DIFF: begin fpu_req.op = clp_pkg::FOP_SUB; fpu_req.a = r_x; fpu_req.b = r_alpha; end
            C_BSQ:  begin fpu_req.a = r_beta; fpu_req.b = r_beta; end
            C_SUM:  begin fpu_req.op = clp_pkg::FOP_ADD; fpu_req.a = r_t2; fpu_req.b = r_t1; end
            C_DEN:  begin fpu_req.a = clp_pkg::PI_BITS; end
            C_DIV:  begin fpu_req.op = clp_pkg::FOP_DIV; fpu_req.a = r_beta; end
            C_PROD: begin fpu_req.a = r_run; end
            default: ;
        endcase
    end

    clp_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fpu_req),
        .o_rsp   (fpu_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= C_IDLE;
            r_start  <= 1'b0;
            r_ovalid <= 1'b0;
            r_alpha  <= 64'd0;
            r_beta   <= clp_pkg::ONE_BITS;
            r_run    <= clp_pkg::ONE_BITS;
        end else begin
            r_start <= 1'b0;
            if (r_ovalid && i_m_axis_tready && (r_state != C_EMIT)) r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    clp_pkg::CFG_ALPHA: r_alpha <= i_cfg_data;
                    clp_pkg::CFG_BETA:  r_beta  <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                C_IDLE: begin
                    if (accept) begin
                        r_x     <= i_s_axis_tdata;
                        r_last  <= i_s_axis_tlast;
                        r_start <= 1'b1;
                        r_state <= C_DIFF;
                    end
                end
                C_DIFF: if (fpu_rsp.done) begin
                    r_t1 <= fpu_rsp.res;  r_start <= 1'b1;  r_state <= C_DSQ;
                end
                C_DSQ: if (fpu_rsp.done) begin
                    r_t1 <= fpu_rsp.res;  r_start <= 1'b1;  r_state <= C_BSQ;
                end
                C_BSQ: if (fpu_rsp.done) begin
                    r_t2 <= fpu_rsp.res;  r_start <= 1'b1;  r_state <= C_SUM;
                end
                C_SUM: if (fpu_rsp.done) begin
                    r_t1 <= fpu_rsp.res;  r_start <= 1'b1;  r_state <= C_DEN;
                end
                C_DEN: if (fpu_rsp.done) begin
                    r_t1 <= fpu_rsp.res;  r_start <= 1'b1;  r_state <= C_DIV;
                end
                C_DIV: if (fpu_rsp.done) begin
                    r_t1 <= fpu_rsp.res;  r_start <= 1'b1;  r_state <= C_PROD;
                end
                C_PROD: if (fpu_rsp.done) begin
                    r_t1 <= fpu_rsp.res;
                    if (r_last) begin
                        r_state <= C_EMIT;
                    end else begin
                        r_run   <= fpu_rsp.res;
                        r_state <= C_IDLE;
                    end
                end
                C_EMIT: begin
                    // hold until the output register is free
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= r_t1;
                        r_run    <= clp_pkg::ONE_BITS;
                        r_state  <= C_IDLE;
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

endmodule

// File: hw/rtl/clp_checker.sv
// Port-level checks for the Cauchy likelihood product core, bound to the top level.
module clp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [63:0] o_m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed");

    // a request starts work: no second request in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("ready right after a request");

    // a new result appears only at the end of work
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
        else $error("result without work");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_s_axis_tready && !o_m_axis_tvalid))
        else $error("bad state after reset");

endmodule

bind cauchy_likelihood_product_core clp_checker u_clp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// File: tb/tb_cauchy_likelihood_product_core.sv
// Testbench for the Cauchy likelihood product core: directed and random data sets, checked against a binary64 predictor.
module tb_cauchy_likelihood_product_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 700;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [63:0] i_s_axis_tdata;   // [63:0] sample_bits
    logic        i_s_axis_tlast;   // last_point
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [63:0] o_m_axis_tdata;   // [63:0] product_bits
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [63:0] i_cfg_data;

    cauchy_likelihood_product_core u_dut (.*);

    // predictor state
    logic [63:0] alpha_bits;
    logic [63:0] beta_bits;
    real         product_so_far;
    logic [63:0] product_queue[$];
    int          error_count;
    int          hold_off_cycles;
    int          stall_cycles;

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    initial begin
        #50ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic real cauchy_density(real x);
        real a, b, diff, diff_sq, beta_sq, sum, denom;
        a       = $bitstoreal(alpha_bits);
        b       = $bitstoreal(beta_bits);
        diff    = x - a;
        diff_sq = diff * diff;
        beta_sq = b * b;
        sum     = beta_sq + diff_sq;
        denom   = $bitstoreal(clp_pkg::PI_BITS) * sum;
        return b / denom;
    endfunction

    function automatic bit is_nan(logic [63:0] v);
        return v[62:52] == 11'h7FF && v[51:0] != 0;
    endfunction

    // Receiver: random stalls, now and then a long one, or a long hold-off when requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            stall_cycles    <= 0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_m_axis_tready <= 1'b0;
        end else if (stall_cycles > 0) begin
            stall_cycles    <= stall_cycles - 1;
            i_m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 199) == 0) begin
            stall_cycles    <= $urandom_range(20, 150);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 9) < 7);
        end
    end

    always @(posedge i_clk) begin
        logic [63:0] want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (product_queue.size() == 0) begin
                $error("product_bits: unexpected result %h", o_m_axis_tdata);
                error_count++;
            end else begin
                want = product_queue.pop_front();
                // NaN payloads are not pinned down by the arithmetic; accept any NaN
                if (is_nan(want) ? !is_nan(o_m_axis_tdata) : (want !== o_m_axis_tdata)) begin
                    $error("product_bits: expected %h, actual %h", want, o_m_axis_tdata);
                    error_count++;
                end
            end
        end
    end

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    task automatic send_sample(logic [63:0] x, logic last, int gap);
        real density;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= x;
        i_s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        density = product_so_far * cauchy_density($bitstoreal(x));
        if (last) begin
            product_queue.push_back($realtobits(density));
            product_so_far = 1.0;
        end else begin
            product_so_far = density;
        end
    endtask

    // Hold the sender until every expected product has come, then let the core settle.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (product_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [63:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == clp_pkg::CFG_ALPHA) alpha_bits = value;
        else                           beta_bits  = value;
    endtask

    task automatic set_shape(logic [63:0] a, logic [63:0] b);
        drain();
        write_reg(clp_pkg::CFG_ALPHA, a);
        write_reg(clp_pkg::CFG_BETA, b);
    endtask

    task automatic test_reset_defaults();
        send_sample(64'h0, 1'b1, 0);                    // x = alpha: peak density
        send_sample($realtobits(2.5), 1'b0, 0);
        send_sample($realtobits(-3.0), 1'b1, 0);
    endtask

    task automatic test_special_operands();
        set_shape($realtobits(1.5), $realtobits(0.25));
        send_sample(64'h7FF0_0000_0000_0000, 1'b1, 0);  // +inf
        send_sample(64'hFFF0_0000_0000_0000, 1'b1, 0);  // -inf
        send_sample(64'h7FF8_0000_0000_0001, 1'b1, 0);  // NaN
        send_sample(64'h7FEF_FFFF_FFFF_FFFF, 1'b1, 0);  // max finite: overflow
        send_sample(64'h8000_0000_0000_0001, 1'b0, 0);  // min subnormal, negative
        send_sample(64'h8000_0000_0000_0000, 1'b1, 0);  // -0
        set_shape($realtobits(1.5), 64'h0);             // zero beta
        send_sample($realtobits(1.5), 1'b1, 0);         // zero denominator: NaN
        send_sample($realtobits(2.0), 1'b1, 0);
        set_shape(64'hFFFF_FFFF_FFFF_FFFF, $realtobits(-2.0));
        send_sample($realtobits(1.0), 1'b1, 0);
        set_shape(64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001);
        send_sample(64'h7FEF_FFFF_FFFF_FFFF, 1'b1, 0);  // diff zero, subnormal beta
        send_sample(64'h0, 1'b1, 0);
        set_shape(64'h0, 64'h7FF0_0000_0000_0000);      // infinite beta
        send_sample(64'h0, 1'b1, 0);
        set_shape(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_sample(64'h1234_5678_9ABC_DEF0, 1'b1, 0);
        set_shape(64'h0, $realtobits(1e-200));          // tiny densities underflow the product
        send_sample($realtobits(1.0), 1'b0, 0);
        send_sample($realtobits(2.0), 1'b0, 0);
        send_sample($realtobits(3.0), 1'b1, 0);
    endtask

    function automatic logic [63:0] random_sample();
        real a, b;
        if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
        a = $bitstoreal(alpha_bits);
        b = $bitstoreal(beta_bits);
        return $realtobits(a + b * (real'(int'($urandom_range(0, 4000)) - 2000) / 200.0));
    endfunction

    task automatic random_shape();
        if ($urandom_range(0, 7) == 0) begin
            set_shape({$urandom, $urandom}, {$urandom, $urandom});
        end else begin
            set_shape($realtobits(real'(int'($urandom_range(0, 2000)) - 1000) / 10.0),
                      $realtobits(real'($urandom_range(1, 500)) / 100.0));
        end
    endtask

    task automatic test_random_sets(int n_items);
        int sent, set_len;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 29) == 0) random_shape();
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 6);
            for (int k = 0; k < set_len; k++) begin
                send_sample(random_sample(), k == set_len - 1, random_gap());
                sent++;
            end
        end
    endtask

    // Hold the receiver long enough that finished products back up into the input.
    task automatic test_receiver_hold_off();
        set_shape($realtobits(-4.0), $realtobits(2.0));
        hold_off_cycles = 4000;
        for (int k = 0; k < 12; k++) send_sample(random_sample(), 1'b1, 0);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tlast  = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = clp_pkg::CFG_ALPHA;
        i_cfg_data      = '0;
        hold_off_cycles = 0;
        error_count     = 0;
        alpha_bits      = 64'h0;
        beta_bits       = clp_pkg::ONE_BITS;
        product_so_far  = 1.0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_special_operands();
        test_receiver_hold_off();
        test_random_sets(1850);
        drain();

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
